/* design/msl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msl_pkg
// Shared types and constants for the motor command slew limiter.
// ----------------------------------------------------------------------------
package msl_pkg;

  typedef logic signed [15:0] req_t;
  typedef logic signed [8:0]  mot_t;
  typedef logic [8:0]         lim_t;
  typedef logic [15:0]        prod_t;

  typedef struct packed {
    logic adv1;
    logic adv2;
  } lane_ctl_t;

  localparam logic signed [15:0] REQ_MAX   = 16'sd400;
  localparam logic signed [15:0] REQ_MIN   = -16'sd400;
  localparam logic signed [16:0] REQ_BIAS  = 17'sd400;
  localparam logic signed [10:0] OUT_BIAS  = 11'sd255;
  // 510/800 = 51/80; /80 done as >>4 then multiply by 3277/2^14 for /5
  localparam logic [5:0]         SCALE_MUL = 6'd51;
  localparam logic [13:0]        RECIP5    = 14'd3277;

endpackage

/* design/msl_scale_lane.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msl_scale_lane
// Two-stage lane: clamp a request to +/-400 and map it to +/-255.
// ----------------------------------------------------------------------------
module msl_scale_lane (
  input  wire logic               clk,
  input  wire msl_pkg::lane_ctl_t ctl,
  input  wire msl_pkg::req_t      req,
  output msl_pkg::mot_t           mapped
);

  msl_pkg::req_t        clamped;
  logic signed [16:0]   biased;
  logic [9:0]           u;
  msl_pkg::prod_t       prod_nxt;
  msl_pkg::prod_t       prod_r;
  logic [11:0]          n;
  logic [23:0]          p;
  logic [9:0]           q;
  logic signed [10:0]   m;
  msl_pkg::mot_t        mapped_nxt;
  msl_pkg::mot_t        mapped_r;

  always_comb begin
    if (req < msl_pkg::REQ_MIN) begin
      clamped = msl_pkg::REQ_MIN;
    end else if (req > msl_pkg::REQ_MAX) begin
      clamped = msl_pkg::REQ_MAX;
    end else begin
      clamped = req;
    end
    biased   = {clamped[15], clamped} + msl_pkg::REQ_BIAS;
    u        = biased[9:0];
    prod_nxt = {6'd0, u} * {10'd0, msl_pkg::SCALE_MUL};
  end

  always_comb begin
    n          = prod_r[15:4];
    p          = {12'd0, n} * {10'd0, msl_pkg::RECIP5};
    q          = p[23:14];
    m          = $signed({1'b0, q}) - msl_pkg::OUT_BIAS;
    mapped_nxt = m[8:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.adv1) begin
      prod_r <= prod_nxt;
    end
    if (ctl.adv2) begin
      mapped_r <= mapped_nxt;
    end
  end

  assign mapped = mapped_r;

endmodule
`default_nettype wire

/* design/msl_drive_limiter.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msl_drive_limiter
// Per-channel step limiter holding the last limited drive value.
// ----------------------------------------------------------------------------
module msl_drive_limiter (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          upd,
  input  wire msl_pkg::mot_t cur,
  input  wire msl_pkg::lim_t lim,
  output msl_pkg::mot_t      limited
);

  msl_pkg::mot_t      prev_r;
  msl_pkg::mot_t      prev_nxt;
  logic               cur_pos;
  logic               cur_neg;
  logic               prev_pos;
  logic               prev_neg;
  logic signed [10:0] pe;
  logic signed [10:0] ce;
  logic signed [10:0] le;
  logic signed [10:0] up;
  logic signed [10:0] dn;

  always_comb begin
    cur_pos  = !cur[8] && (cur != '0);
    cur_neg  = cur[8];
    prev_pos = !prev_r[8] && (prev_r != '0);
    prev_neg = prev_r[8];
    ce       = {{2{cur[8]}}, cur};
    le       = {2'b00, lim};
    if ((cur_pos && prev_neg) || (cur_neg && prev_pos)) begin
      pe = '0;
    end else begin
      pe = {{2{prev_r[8]}}, prev_r};
    end
    up = pe + le;
    dn = pe - le;
    if (lim == '0) begin
      prev_nxt = cur;
    end else if (!pe[10] && cur_pos && (ce > up)) begin
      prev_nxt = up[8:0];
    end else if ((pe <= 0) && cur_neg && (ce < dn)) begin
      prev_nxt = dn[8:0];
    end else begin
      prev_nxt = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (upd) begin
      prev_r <= prev_nxt;
    end
  end

  assign limited = prev_nxt;

endmodule
`default_nettype wire

/* design/motor_command_slew_limiter.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// motor_command_slew_limiter
// Clamps and maps six speed requests, slew-limits the four drive channels,
// applies the motor sign inversions and latches an emergency halt.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  in_*     | input     | in_valid / in_stall  | six requests, stop flag
//  out_*    | output    | out_valid / out_stall| six motor commands, halted
//  cfg_*    | input     | cfg_wr_en            | drive step limit (9 bit)
//
//  One request per cycle while in_stall is low; out_valid rises after two scale stages
//  (two constant multiplies) and the limiter/output stage.
//  Reset clears the limit, the stored drive values and the halt latch.
//  A stalled result holds; stages behind it keep filling until all are full.
// ----------------------------------------------------------------------------
module motor_command_slew_limiter (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [8:0]        cfg_wr_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic signed [15:0] in_right_front_request,
  input  wire logic signed [15:0] in_right_rear_request,
  input  wire logic signed [15:0] in_left_front_request,
  input  wire logic signed [15:0] in_left_rear_request,
  input  wire logic signed [15:0] in_lift_request,
  input  wire logic signed [15:0] in_claw_request,
  input  wire logic              in_stop_request,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic signed [8:0]      out_motor_right_front,
  output logic signed [8:0]      out_motor_right_rear,
  output logic signed [8:0]      out_motor_left_front,
  output logic signed [8:0]      out_motor_left_rear,
  output logic signed [8:0]      out_motor_lift,
  output logic signed [8:0]      out_motor_claw,
  output logic                   out_halted_flag
);

  msl_pkg::lim_t      lim_r;
  logic               v1_r;
  logic               v2_r;
  logic               vo_r;
  logic               stop1_r;
  logic               stop2_r;
  logic               halt_r;
  logic               halt_nxt;
  logic               adv_o;
  logic               adv2;
  logic               adv1;
  logic               fin;
  msl_pkg::lane_ctl_t ctl;
  msl_pkg::req_t      req [6];
  msl_pkg::mot_t      mapped [6];
  msl_pkg::mot_t      limited [4];
  msl_pkg::mot_t      mot_nxt [6];
  msl_pkg::mot_t      mot_r [6];
  logic               halted_r;

  assign adv_o    = !vo_r || !out_stall;
  assign adv2     = !v2_r || adv_o;
  assign adv1     = !v1_r || adv2;
  assign in_stall = !adv1;
  assign fin      = adv_o && v2_r;
  assign ctl.adv1 = adv1;
  assign ctl.adv2 = adv2;
  assign halt_nxt = halt_r || stop2_r;

  assign req[0] = in_right_front_request;
  assign req[1] = in_right_rear_request;
  assign req[2] = in_left_front_request;
  assign req[3] = in_left_rear_request;
  assign req[4] = in_lift_request;
  assign req[5] = in_claw_request;

  for (genvar g = 0; g < 6; g++) begin : g_lane
    msl_scale_lane u_lane (
      .clk    (clk),
      .ctl    (ctl),
      .req    (req[g]),
      .mapped (mapped[g])
    );
  end

  for (genvar g = 0; g < 4; g++) begin : g_drive
    msl_drive_limiter u_lim (
      .clk     (clk),
      .rst_n   (rst_n),
      .upd     (fin && !halt_nxt),
      .cur     (mapped[g]),
      .lim     (lim_r),
      .limited (limited[g])
    );
  end

  always_comb begin
    if (halt_nxt) begin
      for (int i = 0; i < 6; i++) begin
        mot_nxt[i] = '0;
      end
    end else begin
      mot_nxt[0] = limited[0];
      mot_nxt[1] = -limited[1];
      mot_nxt[2] = -limited[2];
      mot_nxt[3] = -limited[3];
      mot_nxt[4] = -mapped[4];
      mot_nxt[5] = mapped[5];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r   <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      vo_r    <= 1'b0;
      halt_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        lim_r <= cfg_wr_data;
      end
      if (adv1) begin
        v1_r <= in_valid;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
      if (adv_o) begin
        vo_r <= v2_r;
      end
      if (fin) begin
        halt_r <= halt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      stop1_r <= in_stop_request;
    end
    if (adv2) begin
      stop2_r <= stop1_r;
    end
    if (fin) begin
      for (int i = 0; i < 6; i++) begin
        mot_r[i] <= mot_nxt[i];
      end
      halted_r <= halt_nxt;
    end
  end

  assign out_valid             = vo_r;
  assign out_motor_right_front = mot_r[0];
  assign out_motor_right_rear  = mot_r[1];
  assign out_motor_left_front  = mot_r[2];
  assign out_motor_left_rear   = mot_r[3];
  assign out_motor_lift        = mot_r[4];
  assign out_motor_claw        = mot_r[5];
  assign out_halted_flag       = halted_r;

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r)
    else $error("halt latch released without reset");

  a_halt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_halted_flag) |-> (out_motor_right_front == '0 &&
      out_motor_right_rear == '0 && out_motor_left_front == '0 &&
      out_motor_left_rear == '0 && out_motor_lift == '0 && out_motor_claw == '0))
    else $error("nonzero motor command while halted");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && v1_r && v2_r))
    else $error("input stalled with room in the pipeline");

  a_halt_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && halt_r) |-> out_halted_flag)
    else $error("halted state not reflected on result");

endmodule
`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the motor command slew limiter. A per-request
// predictor mirrors the request mapping, the per-wheel step limiter, the
// motor sign inversions and the halt latch. Every result is compared field by
// field against the oldest prediction. Traffic runs directed edge cases, then
// random requests over several step-limit settings with random idle and stall
// bursts, and ends with the emergency halt.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int REQ_LIMIT      = 400;
  localparam int CMD_LIMIT      = 255;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 10;

  typedef struct {
    msl_pkg::req_t right_front;
    msl_pkg::req_t right_rear;
    msl_pkg::req_t left_front;
    msl_pkg::req_t left_rear;
    msl_pkg::req_t lift;
    msl_pkg::req_t claw;
    logic stop;
  } speed_req_t;

  typedef struct {
    msl_pkg::mot_t right_front;
    msl_pkg::mot_t right_rear;
    msl_pkg::mot_t left_front;
    msl_pkg::mot_t left_rear;
    msl_pkg::mot_t lift;
    msl_pkg::mot_t claw;
    logic halted;
  } motor_cmd_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [8:0] cfg_wr_data;
  logic in_valid;
  logic in_stall;
  msl_pkg::req_t in_right_front_request;
  msl_pkg::req_t in_right_rear_request;
  msl_pkg::req_t in_left_front_request;
  msl_pkg::req_t in_left_rear_request;
  msl_pkg::req_t in_lift_request;
  msl_pkg::req_t in_claw_request;
  logic in_stop_request;
  logic out_valid;
  logic out_stall;
  msl_pkg::mot_t out_motor_right_front;
  msl_pkg::mot_t out_motor_right_rear;
  msl_pkg::mot_t out_motor_left_front;
  msl_pkg::mot_t out_motor_left_rear;
  msl_pkg::mot_t out_motor_lift;
  msl_pkg::mot_t out_motor_claw;
  logic out_halted_flag;

  motor_command_slew_limiter i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_right_front_request(in_right_front_request),
    .in_right_rear_request (in_right_rear_request),
    .in_left_front_request (in_left_front_request),
    .in_left_rear_request  (in_left_rear_request),
    .in_lift_request       (in_lift_request),
    .in_claw_request       (in_claw_request),
    .in_stop_request       (in_stop_request),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_motor_right_front (out_motor_right_front),
    .out_motor_right_rear  (out_motor_right_rear),
    .out_motor_left_front  (out_motor_left_front),
    .out_motor_left_rear   (out_motor_left_rear),
    .out_motor_lift        (out_motor_lift),
    .out_motor_claw        (out_motor_claw),
    .out_halted_flag       (out_halted_flag)
  );

  // predictor state
  msl_pkg::lim_t step_limit;
  int   drive_hold [4];
  bit   halt_latched;

  motor_cmd_t expected_cmds [$];
  motor_cmd_t want_cmd;
  int errors;
  int requests_sent;
  int results_checked;
  int idle_cycles;
  int gap_pct;
  int stall_pct;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int map_request(msl_pkg::req_t r);
    int x;
    x = r;
    if (x < -REQ_LIMIT) x = -REQ_LIMIT;
    if (x > REQ_LIMIT) x = REQ_LIMIT;
    return (x + REQ_LIMIT) * (2 * CMD_LIMIT) / (2 * REQ_LIMIT) - CMD_LIMIT;
  endfunction

  function automatic int slew_step(int held, int target, int lim);
    if (lim == 0) return target;
    if ((target > 0 && held < 0) || (target < 0 && held > 0)) held = 0;
    if (held >= 0 && target > 0 && target > held + lim) return held + lim;
    if (held <= 0 && target < 0 && target < held - lim) return held - lim;
    return target;
  endfunction

  function automatic motor_cmd_t predict_motor_cmd(speed_req_t r);
    motor_cmd_t c;
    if (r.stop) halt_latched = 1'b1;
    if (halt_latched) begin
      c = '{default: '0};
      c.halted = 1'b1;
      return c;
    end
    drive_hold[0] = slew_step(drive_hold[0], map_request(r.right_front), int'(step_limit));
    drive_hold[1] = slew_step(drive_hold[1], map_request(r.right_rear), int'(step_limit));
    drive_hold[2] = slew_step(drive_hold[2], map_request(r.left_front), int'(step_limit));
    drive_hold[3] = slew_step(drive_hold[3], map_request(r.left_rear), int'(step_limit));
    c.right_front = msl_pkg::mot_t'(drive_hold[0]);
    c.right_rear  = msl_pkg::mot_t'(-drive_hold[1]);
    c.left_front  = msl_pkg::mot_t'(-drive_hold[2]);
    c.left_rear   = msl_pkg::mot_t'(-drive_hold[3]);
    c.lift        = msl_pkg::mot_t'(-map_request(r.lift));
    c.claw        = msl_pkg::mot_t'(map_request(r.claw));
    c.halted      = 1'b0;
    return c;
  endfunction

  function automatic msl_pkg::req_t random_request();
    case ($urandom_range(0, 9))
      0: return msl_pkg::req_t'($urandom);
      1: return $urandom_range(0, 1) ? msl_pkg::req_t'(REQ_LIMIT) :
                                       msl_pkg::req_t'(-REQ_LIMIT);
      default: return msl_pkg::req_t'(int'($urandom_range(0, 900)) - 450);
    endcase
  endfunction

  function automatic speed_req_t random_speed_req(logic stop);
    speed_req_t r;
    r.right_front = random_request();
    r.right_rear  = random_request();
    r.left_front  = random_request();
    r.left_rear   = random_request();
    r.lift        = random_request();
    r.claw        = random_request();
    r.stop        = stop;
    return r;
  endfunction

  function automatic speed_req_t drive_req(int v);
    speed_req_t r;
    r.right_front = msl_pkg::req_t'(v);
    r.right_rear  = msl_pkg::req_t'(-v);
    r.left_front  = msl_pkg::req_t'(v);
    r.left_rear   = msl_pkg::req_t'(-(v / 2));
    r.lift        = msl_pkg::req_t'(v);
    r.claw        = msl_pkg::req_t'(-v);
    r.stop        = 1'b0;
    return r;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_cmds.size() == 0) begin
        $error("motor command with no request pending");
        errors++;
      end else begin
        want_cmd = expected_cmds.pop_front();
        check_field("motor_right_front", want_cmd.right_front, out_motor_right_front);
        check_field("motor_right_rear", want_cmd.right_rear, out_motor_right_rear);
        check_field("motor_left_front", want_cmd.left_front, out_motor_left_front);
        check_field("motor_left_rear", want_cmd.left_rear, out_motor_left_rear);
        check_field("motor_lift", want_cmd.lift, out_motor_lift);
        check_field("motor_claw", want_cmd.claw, out_motor_claw);
        check_field("halted_flag", want_cmd.halted, out_halted_flag);
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", idle_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    int burst;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
        burst = $urandom_range(1, 19);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
    end
  end

  task automatic send_request(speed_req_t r);
    int gap;
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid               <= 1'b1;
    in_right_front_request <= r.right_front;
    in_right_rear_request  <= r.right_rear;
    in_left_front_request  <= r.left_front;
    in_left_rear_request   <= r.left_rear;
    in_lift_request        <= r.lift;
    in_claw_request        <= r.claw;
    in_stop_request        <= r.stop;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_cmds.push_back(predict_motor_cmd(r));
    requests_sent++;
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_cmds.size() != 0) @(posedge clk);
  endtask

  task automatic set_drive_step_limit(msl_pkg::lim_t v);
    wait_for_drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    step_limit = v;
  endtask

  task automatic test_request_mapping();
    int vals [11] = '{-32768, -401, -400, -399, -1, 0, 1, 399, 400, 401, 32767};
    gap_pct   = 0;
    stall_pct = 0;
    foreach (vals[i]) send_request(drive_req(vals[i]));
  endtask

  task automatic test_step_limiter();
    int ramp [9] = '{400, 400, 400, -400, -400, 0, 200, 20, -32768};
    gap_pct   = 20;
    stall_pct = 20;
    set_drive_step_limit(9'd50);
    foreach (ramp[i]) send_request(drive_req(ramp[i]));
    set_drive_step_limit(9'd510);
    send_request(drive_req(400));
    send_request(drive_req(-400));
    set_drive_step_limit(9'd1);
    send_request(drive_req(32767));
    send_request(drive_req(-32768));
  endtask

  task automatic test_random_traffic();
    msl_pkg::lim_t sweep [7];
    sweep = '{9'd0, 9'd1, 9'd510, msl_pkg::lim_t'($urandom_range(2, 20)),
              msl_pkg::lim_t'($urandom_range(2, 509)),
              msl_pkg::lim_t'($urandom_range(2, 509)),
              msl_pkg::lim_t'($urandom_range(100, 509))};
    foreach (sweep[p]) begin
      set_drive_step_limit(sweep[p]);
      gap_pct   = (p % 3 == 2) ? 0 : $urandom_range(5, 30);
      stall_pct = (p % 3 == 1) ? 0 : $urandom_range(5, 30);
      for (int i = 0; i < 270; i++) begin
        // hold until the pipeline is empty once mid-stream
        if (p == 3 && i == 135) wait_for_drain();
        send_request(random_speed_req(1'b0));
      end
    end
  endtask

  task automatic test_emergency_halt();
    gap_pct   = 0;
    stall_pct = 0;
    set_drive_step_limit(9'd30);
    repeat (20) send_request(random_speed_req(1'b0));
    send_request(random_speed_req(1'b1));
    repeat (15) send_request(random_speed_req(1'($urandom_range(0, 1))));
    set_drive_step_limit(9'd0);
    repeat (30) send_request(random_speed_req(1'($urandom_range(0, 1))));
  endtask

  initial begin
    rst_n                  <= 1'b0;
    cfg_wr_en              <= 1'b0;
    cfg_wr_data            <= '0;
    in_valid               <= 1'b0;
    in_right_front_request <= '0;
    in_right_rear_request  <= '0;
    in_left_front_request  <= '0;
    in_left_rear_request   <= '0;
    in_lift_request        <= '0;
    in_claw_request        <= '0;
    in_stop_request        <= 1'b0;
    step_limit   = '0;
    drive_hold   = '{default: 0};
    halt_latched = 1'b0;
    errors = 0;
    requests_sent = 0;
    results_checked = 0;
    idle_cycles = 0;
    gap_pct = 0;
    stall_pct = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_request_mapping();
    test_step_limiter();
    test_random_traffic();
    test_emergency_halt();

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Ran %0d speed requests and checked %0d motor commands", requests_sent,
             results_checked);
    $display("over step limits 0, 1, 50, 510 and random values, ending in a latched halt");
    if (errors == 0 && expected_cmds.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* files.f */
design/msl_pkg.sv
design/msl_scale_lane.sv
design/msl_drive_limiter.sv
design/motor_command_slew_limiter.sv
sim/tb_top.sv
